@@ design/bra_pkg.sv @@
`default_nettype none

package bra_pkg;

    localparam int MAP_BYTES = 1024;
    localparam int ADDR_W    = $clog2(MAP_BYTES);
    localparam int USED_W    = $clog2(MAP_BYTES + 1);
    localparam int BIT_W     = ADDR_W + 3;

    localparam int OP_W      = 2;
    localparam int BADDR_W   = 10;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 12;
    localparam int INDEX_W   = 24;
    localparam int STATUS_W  = 2;
    localparam int CFG_USED_W = 11;
    localparam int CFG_BASE_W = 23;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_USED_W-1:0] CFG_USED_RST = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_BYTES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET      = 1'b1;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BADDR_W-1:0] byte_addr;
        logic [BYTE_W-1:0]  write_byte;
        logic [LEN_W-1:0]   run_length;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_byte;
        logic [INDEX_W-1:0]  first_index;
        logic [STATUS_W-1:0] status;
    } t_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_RANGE,
        S_CHECK,
        S_SET,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ design/bitmap_run_allocator_core.sv @@
`default_nettype none
// First-fit run allocator over a byte bitmap (set bit = used unit).
// Input channel (i_in_valid / o_in_ready, i_in_data): one operation per beat:
// write a map byte, read a map byte, or allocate a run of consecutive bits.
// Output channel (o_out_valid / i_out_ready, o_out_data): one result beat per
// input beat, in order. Config channel (i_cfg_valid / o_cfg_ready): index 0
// sets the bytes in use, index 1 the base offset; always ready.
// Allocation scans the map one byte per cycle through the single read port of the
// map RAM, then checks and sets the bytes of the run one per cycle. A result
// enters the output register as the core returns to idle, where the next beat
// can be taken. One operation is in work at a time.
// The output register parts both sides: a new beat is taken while a result
// waits; if the receiver stalls, the next finished result waits in the core
// and input is held off until the output register frees.
// Reset: synchronous, active low. After reset a clearing pass writes zero to
// all 1024 map bytes, one per cycle; no input beat is taken during it.
module bitmap_run_allocator_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire bra_pkg::t_in                 i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output bra_pkg::t_out                     o_out_data,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [bra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bra_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bra_pkg::*;

    localparam int TOT_W = USED_W + 3;
    localparam int CMP_W = (TOT_W > LEN_W) ? TOT_W : LEN_W;

    t_state r_state, n_state;

    logic [CFG_USED_W-1:0] r_cfg_used;
    logic [CFG_BASE_W-1:0] r_base;

    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_last, n_last;
    logic [USED_W-1:0] r_used, n_used;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BIT_W-1:0]  r_start, n_start;
    logic [BIT_W-1:0]  r_end, n_end;
    logic              r_inr, n_inr;
    t_out              r_res, n_res;
    logic              r_out_valid;
    t_out              r_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              in_acc;
    logic              out_free;
    logic              found;
    logic              scan_last;
    logic              at_end;
    logic              chk_hit;
    logic              range_bad;
    logic              addr_ok;
    logic [USED_W-1:0] used_sat;
    logic [2:0]        low_clear;
    logic [2:0]        mask_lo;
    logic [2:0]        mask_hi;
    logic [BYTE_W-1:0] cur_mask;
    logic [TOT_W-1:0]  total_bits;
    logic [ADDR_W-1:0] ptr_inc;

    bra_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAP_BYTES)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign found     = (ram_rdata != BYTE_FULL);
    assign scan_last = (r_ptr == r_last);
    assign at_end    = (r_ptr == r_end[BIT_W-1:3]);
    assign ptr_inc   = ADDR_W'(r_ptr + 1'b1);
    assign addr_ok   = (32'(i_in_data.byte_addr) < 32'(MAP_BYTES));
    assign used_sat  = (32'(r_cfg_used) > 32'(MAP_BYTES)) ? USED_W'(MAP_BYTES)
                                                          : USED_W'(r_cfg_used);
    assign total_bits = {r_used, 3'b000};
    assign range_bad  = CMP_W'(r_len) > (CMP_W'(total_bits) - CMP_W'(r_start));

    always_comb begin
        low_clear = 3'd7;
        for (int b = 6; b >= 0; b--) begin
            if (!ram_rdata[b]) begin
                low_clear = 3'(b);
            end
        end
    end

    assign mask_lo  = (r_ptr == r_start[BIT_W-1:3]) ? r_start[2:0] : 3'd0;
    assign mask_hi  = (r_ptr == r_end[BIT_W-1:3]) ? r_end[2:0] : 3'd7;
    assign cur_mask = (BYTE_FULL << mask_lo) & (BYTE_FULL >> (3'd7 - mask_hi));
    assign chk_hit  = |(ram_rdata & cur_mask);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_W'(MAP_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.op)
                        OP_READ:  n_state = S_READ;
                        OP_ALLOC: n_state = (used_sat == '0) ? S_OUT : S_SCAN;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_READ: n_state = S_OUT;
            S_SCAN: begin
                if (found) begin
                    n_state = S_RANGE;
                end else if (scan_last) begin
                    n_state = S_OUT;
                end
            end
            S_RANGE: n_state = range_bad ? S_OUT : S_CHECK;
            S_CHECK: begin
                if (chk_hit) begin
                    n_state = S_OUT;
                end else if (at_end) begin
                    n_state = S_SET;
                end
            end
            S_SET: begin
                if (at_end) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr     = r_clr;
        n_ptr     = r_ptr;
        n_last    = r_last;
        n_used    = r_used;
        n_len     = r_len;
        n_start   = r_start;
        n_end     = r_end;
        n_inr     = r_inr;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = ram_rdata | cur_mask;
        ram_raddr = ptr_inc;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = ADDR_W'(r_clr + 1'b1);
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    case (i_in_data.op)
                        OP_WRITE: begin
                            ram_we    = addr_ok;
                            ram_waddr = ADDR_W'(i_in_data.byte_addr);
                            ram_wdata = i_in_data.write_byte;
                        end
                        OP_READ: begin
                            ram_raddr = ADDR_W'(i_in_data.byte_addr);
                            n_inr     = addr_ok;
                        end
                        OP_ALLOC: begin
                            ram_raddr = '0;
                            n_ptr     = '0;
                            n_used    = used_sat;
                            n_last    = ADDR_W'(used_sat - 1'b1);
                            n_len     = (i_in_data.run_length == '0) ? LEN_W'(1)
                                                                     : i_in_data.run_length;
                            if (used_sat == '0) begin
                                n_res.status = ST_FULL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res.read_byte = r_inr ? ram_rdata : '0;
            end
            S_SCAN: begin
                if (found) begin
                    n_start = {r_ptr, low_clear};
                end else if (scan_last) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            S_RANGE: begin
                if (range_bad) begin
                    n_res.status = ST_ERROR;
                end else begin
                    n_end     = BIT_W'(CMP_W'(r_start) + CMP_W'(r_len) - CMP_W'(1));
                    ram_raddr = r_start[BIT_W-1:3];
                    n_ptr     = r_start[BIT_W-1:3];
                end
            end
            S_CHECK: begin
                if (chk_hit) begin
                    n_res.status = ST_ERROR;
                end else if (at_end) begin
                    ram_raddr = r_start[BIT_W-1:3];
                    n_ptr     = r_start[BIT_W-1:3];
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            S_SET: begin
                ram_we = 1'b1;
                if (at_end) begin
                    n_res.status      = ST_OK;
                    n_res.first_index = INDEX_W'(r_start) + INDEX_W'(r_base);
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cfg_used  <= CFG_USED_RST;
            r_base      <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAP_BYTES_IN_USE: r_cfg_used <= i_cfg_data[CFG_USED_W-1:0];
                    REG_BASE_OFFSET:      r_base     <= i_cfg_data[CFG_BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_last  <= n_last;
        r_used  <= n_used;
        r_len   <= n_len;
        r_start <= n_start;
        r_end   <= n_end;
        r_inr   <= n_inr;
        r_res   <= n_res;
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

endmodule

`default_nettype wire

@@ design/bra_ram.sv @@
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ test/tb_bitmap_run_allocator_core.sv @@
`timescale 1ns / 1ps

module tb_bitmap_run_allocator_core;
    import bra_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 50;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 60;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_in                   item;
        bit                    checked;
        t_out                  want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in                   in_data = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    bit                    row_checked = 1'b0;
    t_out                  row_want = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  o_cfg_ready;

    logic [BYTE_W-1:0]     shadow_map [MAP_BYTES];
    logic [CFG_USED_W-1:0] bytes_in_use = CFG_USED_RST;
    logic [CFG_BASE_W-1:0] base_offset = '0;
    t_out                  pending_results [$];
    t_row                  stim_rows [$];
    int                    err_count = 0;
    int                    idle_cycles = 0;
    int                    tx_burst = 0;
    int                    rx_hold = 0;
    int                    rx_pct = 0;
    int                    rx_cycle = 0;

    bitmap_run_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        for (int a = 0; a < MAP_BYTES; a++) begin
            shadow_map[a] = '0;
        end
    end

    function automatic t_out predict_result(t_in x);
        t_out        r;
        int          used;
        int          len;
        int          first_free;
        int          start;
        int          bit_idx;
        int          n;
        bit          found;
        bit          clash;
        logic [31:0] sum;
        r = '0;
        case (x.op)
            OP_WRITE: shadow_map[x.byte_addr] = x.write_byte;
            OP_READ:  r.read_byte = shadow_map[x.byte_addr];
            OP_ALLOC: begin
                used = (int'(bytes_in_use) > MAP_BYTES) ? MAP_BYTES : int'(bytes_in_use);
                len = (x.run_length == '0) ? 1 : int'(x.run_length);
                found = 1'b0;
                first_free = 0;
                for (n = 0; n < used && !found; n++) begin
                    if (shadow_map[n] != BYTE_FULL) begin
                        found = 1'b1;
                        first_free = n;
                    end
                end
                if (!found) begin
                    r.status = ST_FULL;
                end else begin
                    n = 0;
                    while (n < 7 && shadow_map[first_free][n]) n++;
                    start = first_free * 8 + n;
                    if (len > used * 8 - start) begin
                        r.status = ST_ERROR;
                    end else begin
                        clash = 1'b0;
                        for (n = 0; n < len; n++) begin
                            bit_idx = start + n;
                            if (shadow_map[bit_idx / 8][bit_idx % 8]) clash = 1'b1;
                        end
                        if (clash) begin
                            r.status = ST_ERROR;
                        end else begin
                            for (n = 0; n < len; n++) begin
                                bit_idx = start + n;
                                shadow_map[bit_idx / 8][bit_idx % 8] = 1'b1;
                            end
                            sum = 32'(start) + 32'(base_offset);
                            r.first_index = sum[INDEX_W-1:0];
                            r.status = ST_OK;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // monitor: config shadow, result check, expectation push, watchdog
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) begin
                if (cfg_index == REG_MAP_BYTES_IN_USE) begin
                    bytes_in_use = cfg_data[CFG_USED_W-1:0];
                end else begin
                    base_offset = cfg_data[CFG_BASE_W-1:0];
                end
            end
            if (o_out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", 32'(o_out_data), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.read_byte != want.read_byte)
                        report_mismatch("read_byte", 32'(o_out_data.read_byte),
                                        32'(want.read_byte));
                    if (o_out_data.first_index != want.first_index)
                        report_mismatch("first_index", 32'(o_out_data.first_index),
                                        32'(want.first_index));
                    if (o_out_data.status != want.status)
                        report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                end
            end
            if (in_valid && o_in_ready) begin
                want = predict_result(in_data);
                if (row_checked) want = row_want;
                pending_results.push_back(want);
            end
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                    $display("** bitmap_run_allocator_core: FAILED **");
                    $finish;
                end
            end
        end
    end

    // receiver stall pattern, stall rate redrawn periodically from three levels
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 400 == 0) begin
            case ($urandom_range(0, 2))
                0:       rx_pct = 0;
                1:       rx_pct = 10;
                default: rx_pct = 35;
            endcase
        end
        if (rx_hold > 0) begin
            rx_hold--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < rx_pct) rx_hold = $urandom_range(1, 20);
        end
    end

    task automatic send_item(input t_in x, input bit chk, input t_out want);
        int gap;
        if (tx_burst == 0) begin
            gap = $urandom_range(1, 8);
            tx_burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tx_burst--;
        in_valid    <= 1'b1;
        in_data     <= x;
        row_checked <= chk;
        row_want    <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in make_item(input logic [OP_W-1:0] op, input int addr,
                                      input int wbyte, input int len);
        t_in x;
        x.op = op;
        x.byte_addr = BADDR_W'(addr);
        x.write_byte = BYTE_W'(wbyte);
        x.run_length = LEN_W'(len);
        return x;
    endfunction

    function automatic void add_item(input logic [OP_W-1:0] op, input int addr,
                                     input int wbyte, input int len);
        t_row r;
        r = '{default: '0};
        r.item = make_item(op, addr, wbyte, len);
        stim_rows.push_back(r);
    endfunction

    function automatic void add_checked(input logic [OP_W-1:0] op, input int addr,
                                        input int wbyte, input int len, input int rbyte,
                                        input int index, input logic [STATUS_W-1:0] st);
        t_row r;
        r = '{default: '0};
        r.item = make_item(op, addr, wbyte, len);
        r.checked = 1'b1;
        r.want.read_byte = BYTE_W'(rbyte);
        r.want.first_index = INDEX_W'(index);
        r.want.status = st;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_row r;
        r = '{default: '0};
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_data = CFG_DATA_W'(data);
        stim_rows.push_back(r);
    endfunction

    function automatic t_in random_item(input int span);
        t_in x;
        int  sel;
        x.op = OP_WRITE;
        x.byte_addr = ($urandom_range(0, 4) == 0) ? BADDR_W'($urandom_range(0, MAP_BYTES - 1))
                                                  : BADDR_W'($urandom_range(0, span - 1));
        x.write_byte = ($urandom_range(0, 9) < 4) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 70)      x.run_length = LEN_W'($urandom_range(1, 8));
        else if (sel < 90) x.run_length = LEN_W'($urandom_range(0, 64));
        else if (sel < 98) x.run_length = LEN_W'($urandom_range(0, 4095));
        else               x.run_length = '0;
        sel = $urandom_range(0, 99);
        if (sel < 45)      x.op = OP_ALLOC;
        else if (sel < 65) x.op = OP_READ;
        else if (sel < 94) x.op = OP_WRITE;
        else               x.op = OP_NONE;
        return x;
    endfunction

    initial begin
        int                    used_sel;
        int                    span;
        logic [CFG_DATA_W-1:0] data;
        t_row                  row;

        // reset values: 1024 bytes in use, base 0, empty map
        add_checked(OP_READ,  0,    8'h00, 0,     8'h00, 0, ST_OK);
        add_checked(OP_READ,  1023, 8'hff, 4095,  8'h00, 0, ST_OK);
        add_checked(OP_ALLOC, 0,    8'h00, 1,     8'h00, 0, ST_OK);
        add_checked(OP_ALLOC, 0,    8'h00, 0,     8'h00, 1, ST_OK);
        add_checked(OP_ALLOC, 0,    8'h00, 6,     8'h00, 2, ST_OK);
        add_checked(OP_READ,  0,    8'h00, 0,     8'hff, 0, ST_OK);
        add_checked(OP_WRITE, 1,    8'h10, 0,     8'h00, 0, ST_OK);
        add_checked(OP_ALLOC, 0,    8'h00, 8,     8'h00, 0, ST_ERROR);
        add_checked(OP_ALLOC, 1023, 8'hff, 4095,  8'h00, 0, ST_ERROR);
        add_checked(OP_WRITE, 1023, 8'hff, 0,     8'h00, 0, ST_OK);
        add_checked(OP_READ,  1023, 8'h00, 0,     8'hff, 0, ST_OK);
        add_checked(OP_NONE,  1023, 8'hff, 4095,  8'h00, 0, ST_OK);
        add_item(OP_ALLOC, 0, 8'h00, 3);
        // one byte in use, largest base
        add_reg(REG_MAP_BYTES_IN_USE, 1);
        add_reg(REG_BASE_OFFSET, 23'h7fffff);
        add_checked(OP_WRITE, 0,    8'h00, 0,     8'h00, 0, ST_OK);
        add_checked(OP_ALLOC, 0,    8'h00, 8,     8'h00, 23'h7fffff, ST_OK);
        add_checked(OP_ALLOC, 0,    8'h00, 1,     8'h00, 0, ST_FULL);
        add_checked(OP_WRITE, 0,    8'h7f, 0,     8'h00, 0, ST_OK);
        add_checked(OP_ALLOC, 0,    8'h00, 2,     8'h00, 0, ST_ERROR);
        // no bytes in use
        add_reg(REG_MAP_BYTES_IN_USE, 0);
        add_checked(OP_ALLOC, 0,    8'h00, 1,     8'h00, 0, ST_FULL);
        // above the map size: saturates
        add_reg(REG_MAP_BYTES_IN_USE, 23'h7fffff);
        add_reg(REG_BASE_OFFSET, 23'h2aaaaa);
        add_item(OP_ALLOC, 0, 8'h00, 3);
        add_item(OP_ALLOC, 0, 8'h00, 12);
        add_item(OP_READ, 1, 8'h00, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            row = stim_rows[r];
            if (row.is_reg) begin
                wait_drained();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_item(row.item, row.checked, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       used_sel = 1024;
                1:       used_sel = $urandom_range(1, 16);
                2:       used_sel = $urandom_range(8, 96);
                3:       used_sel = 1;
                4:       used_sel = 2047;
                5:       used_sel = $urandom_range(1, 2047);
                6:       used_sel = $urandom_range(2, 12);
                7:       used_sel = 0;
                default: used_sel = $urandom_range(16, 64);
            endcase
            span = (used_sel == 0) ? 1 : (used_sel > MAP_BYTES) ? MAP_BYTES : used_sel;
            wait_drained();
            data = CFG_DATA_W'($urandom);
            data[CFG_USED_W-1:0] = CFG_USED_W'(used_sel);
            write_reg(REG_MAP_BYTES_IN_USE, data);
            case (p % 3)
                0:       data = '0;
                1:       data = 23'h7fffff;
                default: data = CFG_DATA_W'($urandom);
            endcase
            write_reg(REG_BASE_OFFSET, data);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 25) wait_drained();
                send_item(random_item(span), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", pending_results.size(), 0);
        if (err_count == 0) begin
            $display("** bitmap_run_allocator_core: PASSED **");
        end else begin
            $display("** bitmap_run_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule
